// ----- hw/rtl/slot_free_list_allocator_defines.svh -----
// assertion macros for the slot free-list allocator
`ifndef SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define SFLA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// property on the cycle after a condition
`define SFLA_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);
`else
`define SFLA_ASSERT(label, clk, rstn, prop, msg)
`define SFLA_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

// ----- hw/rtl/sfla_pkg.sv -----
// types and constants for the slot free-list allocator
`timescale 1ns / 1ps

package sfla_pkg;

    localparam int SLOT_COUNT   = 256;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_FIELD_W = 8;
    localparam int CMP_W        = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int MBX_W        = 16;
    localparam int MSG_W        = 16;
    localparam int WST_W        = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic [MBX_W-1:0] mailbox;
        logic [MSG_W-1:0] message;
        logic [WST_W-1:0] wait_state;
    } record_t;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [CNT_W-1:0]  slot_cnt_t;

endpackage

// ----- hw/rtl/slot_free_list_allocator.sv -----
// slot free-list allocator top level: record table, free stack and result register
`timescale 1ns / 1ps
`include "slot_free_list_allocator_defines.svh"

// channel | ports                                        | direction
// --------+----------------------------------------------+----------
// command | s_valid s_ready s_command s_slot s_mailbox   | in
//         | s_message_code s_wait_state                  |
// result  | m_valid m_ready m_status m_slot_out          | out
//         | m_occupied m_mailbox_out m_message_out       |
//         | m_wait_state_out                             |
//
// one beat per cycle sustained while results are taken; a result passes the operand register
// (with registered slot-table reads), then the result register
// all table updates happen in the execute stage, which the next command's reads
// see through a same-cycle bypass
// aresetn (synchronous) clears the pipeline valids, the used-end count and the
// free count; no clearing pass, the tables need none
// a held result stalls the execute stage, which drops s_ready

module slot_free_list_allocator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sfla_pkg::CMD_W-1:0]          s_command,
    input  logic [sfla_pkg::SLOT_FIELD_W-1:0]   s_slot,
    input  logic [sfla_pkg::MBX_W-1:0]          s_mailbox,
    input  logic [sfla_pkg::MSG_W-1:0]          s_message_code,
    input  logic [sfla_pkg::WST_W-1:0]          s_wait_state,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sfla_pkg::STATUS_W-1:0]       m_status,
    output logic [sfla_pkg::SLOT_FIELD_W-1:0]   m_slot_out,
    output logic                                m_occupied,
    output logic [sfla_pkg::MBX_W-1:0]          m_mailbox_out,
    output logic [sfla_pkg::MSG_W-1:0]          m_message_out,
    output logic [sfla_pkg::WST_W-1:0]          m_wait_state_out
);
    import sfla_pkg::*;

    // slot tables: live flag and record per slot
    logic    live_mem [SLOT_COUNT];
    record_t rec_mem  [SLOT_COUNT];
    // free list kept as a stack: depth d holds the d-th oldest free slot
    slot_idx_t stack_mem [SLOT_COUNT];

    // execute stage operands
    logic                    s1_valid_reg;
    cmd_t                    s1_cmd_reg;
    logic [SLOT_FIELD_W-1:0] s1_slot_reg;
    record_t                 s1_rec_reg;
    logic                    rd_live_reg;
    record_t                 rd_rec_reg;

    // allocator state
    slot_cnt_t used_end_reg, used_end_next;
    slot_cnt_t free_cnt_reg, free_cnt_next;
    slot_idx_t free_top_reg, free_top_next;   // head of the free list
    slot_idx_t free_below_reg;                // entry just under the head

    // result register
    logic                    m_valid_reg;
    status_t                 m_status_reg, status_next;
    logic [SLOT_FIELD_W-1:0] m_slot_reg, slot_out_next;
    logic                    m_occ_reg, occ_next;
    record_t                 m_rec_reg, rec_out_next;

    logic      advance;
    logic      s_accept;
    logic      in_use;
    slot_idx_t s_idx;
    slot_idx_t s1_idx;
    slot_idx_t wr_idx;
    slot_idx_t stk_rd_idx;
    logic      live_we;
    logic      live_wdata;
    logic      rec_we;
    logic      push;

    // execute when the result register is free or being emptied
    assign advance  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign s_idx  = SLOT_W'(s_slot);
    assign s1_idx = SLOT_W'(s1_slot_reg);
    // slots below used_end are all inside the table
    assign in_use = CMP_W'(s1_slot_reg) < CMP_W'(used_end_reg);

    always_comb begin
        used_end_next = used_end_reg;
        free_cnt_next = free_cnt_reg;
        free_top_next = free_top_reg;
        wr_idx        = s1_idx;
        live_we       = 1'b0;
        live_wdata    = 1'b0;
        rec_we        = 1'b0;
        push          = 1'b0;
        status_next   = ST_OK;
        slot_out_next = s1_slot_reg;
        occ_next      = 1'b0;
        rec_out_next  = '0;
        case (s1_cmd_reg)
            CMD_ALLOC: begin
                if (free_cnt_reg != '0) begin
                    // pop the free-list head
                    wr_idx        = free_top_reg;
                    free_top_next = free_below_reg;
                    free_cnt_next = free_cnt_reg - CNT_W'(1);
                    live_we       = 1'b1;
                    live_wdata    = 1'b1;
                    rec_we        = 1'b1;
                    slot_out_next = SLOT_FIELD_W'(free_top_reg);
                end else if (used_end_reg < CNT_W'(SLOT_COUNT)) begin
                    // grow the table at its end
                    wr_idx        = used_end_reg[SLOT_W-1:0];
                    used_end_next = used_end_reg + CNT_W'(1);
                    live_we       = 1'b1;
                    live_wdata    = 1'b1;
                    rec_we        = 1'b1;
                    slot_out_next = SLOT_FIELD_W'(used_end_reg);
                end else begin
                    status_next   = ST_FULL;
                    slot_out_next = '0;
                end
            end
            CMD_FREE: begin
                if (!in_use) begin
                    status_next = ST_NOT_FOUND;
                end else if (rd_live_reg) begin
                    // push onto the free list; freeing a free slot changes nothing
                    live_we       = 1'b1;
                    push          = 1'b1;
                    free_top_next = s1_idx;
                    free_cnt_next = free_cnt_reg + CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (!in_use) begin
                    status_next = ST_NOT_FOUND;
                end else if (rd_live_reg) begin
                    occ_next     = 1'b1;
                    rec_out_next = rd_rec_reg;
                end
            end
            CMD_WRITE: begin
                if (in_use && rd_live_reg) begin
                    rec_we = 1'b1;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // the entry under the new head sits at depth free_cnt_next - 2
    assign stk_rd_idx = SLOT_W'(free_cnt_next - CNT_W'(2));

    // table writes and bypassed reads
    always_ff @(posedge aclk) begin
        if (advance && live_we) begin
            live_mem[wr_idx] <= live_wdata;
        end
        if (advance && rec_we) begin
            rec_mem[wr_idx] <= s1_rec_reg;
        end
        if (advance && push) begin
            stack_mem[free_cnt_reg[SLOT_W-1:0]] <= s1_idx;
        end
        if (advance) begin
            free_below_reg <= stack_mem[stk_rd_idx];
        end
        if (s_accept) begin
            // same-slot write in this cycle wins over the old table contents
            rd_live_reg <= (advance && live_we && (wr_idx == s_idx)) ? live_wdata
                                                                     : live_mem[s_idx];
            rd_rec_reg  <= (advance && rec_we && (wr_idx == s_idx)) ? s1_rec_reg
                                                                    : rec_mem[s_idx];
        end
    end

    // operand register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg  <= cmd_t'(s_command);
            s1_slot_reg <= s_slot;
            s1_rec_reg  <= '{mailbox: s_mailbox, message: s_message_code,
                             wait_state: s_wait_state};
        end
    end

    // allocator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_end_reg <= '0;
            free_cnt_reg <= '0;
        end else if (advance) begin
            used_end_reg <= used_end_next;
            free_cnt_reg <= free_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            free_top_reg <= free_top_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_status_reg <= status_next;
            m_slot_reg   <= slot_out_next;
            m_occ_reg    <= occ_next;
            m_rec_reg    <= rec_out_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_slot_out       = m_slot_reg;
    assign m_occupied       = m_occ_reg;
    assign m_mailbox_out    = m_rec_reg.mailbox;
    assign m_message_out    = m_rec_reg.message;
    assign m_wait_state_out = m_rec_reg.wait_state;

    // free slots are always a subset of the used ones
    `SFLA_ASSERT(a_free_within_used, aclk, aresetn, free_cnt_reg <= used_end_reg, "free count above used end")
    `SFLA_ASSERT(a_used_end_bound, aclk, aresetn, used_end_reg <= CNT_W'(SLOT_COUNT), "used end beyond table")
    // the table never shrinks
    `SFLA_ASSERT_NEXT(a_used_end_grows, aclk, aresetn, 1'b1, used_end_reg >= $past(used_end_reg), "used end decreased")
    // the free list only moves when a command executes
    `SFLA_ASSERT_NEXT(a_free_cnt_hold, aclk, aresetn, !advance, $stable(free_cnt_reg), "free count moved while stalled")

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the slot free-list allocator: directed and random command beats checked by a predictor
`timescale 1ns / 1ps

module tb_top;
    import sfla_pkg::*;

    // receiver hold-off used to back the block up, and the no-progress timeout
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    // spare cycles after the last result catch stray beats at the end
    localparam int DRAIN_CYCLES = 8;

    // one expected result beat
    typedef struct packed {
        status_t                  status;
        logic [SLOT_FIELD_W-1:0]  slot_out;
        logic                     occupied;
        record_t                  rec;
    } reply_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_command;
    logic [SLOT_FIELD_W-1:0]  s_slot;
    logic [MBX_W-1:0]         s_mailbox;
    logic [MSG_W-1:0]         s_message_code;
    logic [WST_W-1:0]         s_wait_state;
    logic                     m_valid;
    logic                     m_ready;
    logic [STATUS_W-1:0]      m_status;
    logic [SLOT_FIELD_W-1:0]  m_slot_out;
    logic                     m_occupied;
    logic [MBX_W-1:0]         m_mailbox_out;
    logic [MSG_W-1:0]         m_message_out;
    logic [WST_W-1:0]         m_wait_state_out;

    // shadow copy of the slot table, advanced at every accepted command beat
    int      list_head = SLOT_COUNT;   // SLOT_COUNT marks an empty free list
    int      table_end = 0;            // slots in use so far, never shrinks
    int      link_of [SLOT_COUNT];
    bit      live    [SLOT_COUNT];
    record_t stored  [SLOT_COUNT];

    reply_t  pending_replies [$];
    int      mismatch_count = 0;

    // idling knobs shared between the stimulus and the result sink
    bit      src_idle     = 1'b0;
    bit      sink_idle    = 1'b0;
    bit      hold_request = 1'b0;

    always #5 aclk = ~aclk;

    slot_free_list_allocator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_slot           (s_slot),
        .s_mailbox        (s_mailbox),
        .s_message_code   (s_message_code),
        .s_wait_state     (s_wait_state),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot_out       (m_slot_out),
        .m_occupied       (m_occupied),
        .m_mailbox_out    (m_mailbox_out),
        .m_message_out    (m_message_out),
        .m_wait_state_out (m_wait_state_out)
    );

    // applies one command to the shadow table and returns the result it must give
    function automatic reply_t apply_command(input cmd_t cmd,
                                             input logic [SLOT_FIELD_W-1:0] slot,
                                             input record_t rec);
        reply_t r;
        int     pos;
        bit     in_use;
        r          = '0;
        r.status   = ST_OK;
        r.slot_out = slot;
        in_use     = int'(slot) < table_end;
        case (cmd)
            CMD_ALLOC: begin
                // free list first, then grow at the end, else full
                if (list_head < SLOT_COUNT) begin
                    pos       = list_head;
                    list_head = link_of[pos];
                end else if (table_end < SLOT_COUNT) begin
                    pos       = table_end;
                    table_end = table_end + 1;
                end else begin
                    pos = SLOT_COUNT;
                end
                if (pos < SLOT_COUNT) begin
                    live[pos]   = 1'b1;
                    stored[pos] = rec;
                    r.slot_out  = SLOT_FIELD_W'(pos);
                end else begin
                    r.status   = ST_FULL;
                    r.slot_out = '0;
                end
            end
            CMD_FREE: begin
                // freeing a free slot is a quiet success
                if (!in_use) begin
                    r.status = ST_NOT_FOUND;
                end else if (live[slot]) begin
                    live[slot]    = 1'b0;
                    link_of[slot] = list_head;
                    list_head     = slot;
                end
            end
            CMD_READ: begin
                if (!in_use) begin
                    r.status = ST_NOT_FOUND;
                end else if (live[slot]) begin
                    r.occupied = 1'b1;
                    r.rec      = stored[slot];
                end
            end
            default: begin
                if (in_use && live[slot]) begin
                    stored[slot] = rec;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
        endcase
        return r;
    endfunction

    function automatic record_t random_record();
        record_t rec;
        rec.mailbox    = MBX_W'($urandom);
        rec.message    = MSG_W'($urandom);
        rec.wait_state = WST_W'($urandom);
        return rec;
    endfunction

    // weights in percent; whatever is left over goes to write
    function automatic cmd_t pick_command(input int w_alloc, input int w_free, input int w_read);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_alloc) return CMD_ALLOC;
        if (r < w_alloc + w_free) return CMD_FREE;
        if (r < w_alloc + w_free + w_read) return CMD_READ;
        return CMD_WRITE;
    endfunction

    // mostly slots in use, free and write lean toward live ones; now and then anything
    function automatic logic [SLOT_FIELD_W-1:0] pick_slot(input cmd_t cmd);
        int idx;
        int tries;
        if (table_end == 0 || $urandom_range(0, 9) == 0) return SLOT_FIELD_W'($urandom);
        idx = $urandom_range(0, table_end - 1);
        if (cmd == CMD_FREE || cmd == CMD_WRITE) begin
            for (tries = 0; tries < 4 && !live[idx]; tries++)
                idx = $urandom_range(0, table_end - 1);
        end
        return SLOT_FIELD_W'(idx);
    endfunction

    // drives one command beat, waits for the handshake and logs the expected result;
    // valid is left high at the accept edge so a back-to-back beat needs no toggle
    task automatic send_command(input cmd_t cmd, input logic [SLOT_FIELD_W-1:0] slot,
                                input record_t rec);
        int gap;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_slot         <= slot;
        s_mailbox      <= rec.mailbox;
        s_message_code <= rec.message;
        s_wait_state   <= rec.wait_state;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_replies.push_back(apply_command(cmd, slot, rec));
    endtask

    // sender goes quiet until every expected result has come back
    task automatic wait_for_replies();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_reply();
        reply_t want;
        if (pending_replies.size() == 0) begin
            $error("result beat with nothing expected: status %0d slot %0d",
                   m_status, m_slot_out);
            mismatch_count++;
            return;
        end
        want = pending_replies.pop_front();
        compare_field("status",         16'(want.status),         16'(m_status));
        compare_field("slot_out",       16'(want.slot_out),       16'(m_slot_out));
        compare_field("occupied",       16'(want.occupied),       16'(m_occupied));
        compare_field("mailbox_out",    want.rec.mailbox,         m_mailbox_out);
        compare_field("message_out",    want.rec.message,         m_message_out);
        compare_field("wait_state_out", 16'(want.rec.wait_state), 16'(m_wait_state_out));
    endtask

    // everything on an empty table lands beyond the used end
    task automatic test_empty_table();
        send_command(CMD_READ,  8'h00, random_record());
        send_command(CMD_FREE,  8'h00, random_record());
        send_command(CMD_WRITE, 8'h00, random_record());
        send_command(CMD_READ,  8'hFF, random_record());
    endtask

    // each command and its corner cases on a small table
    task automatic test_basic_ops();
        send_command(CMD_ALLOC, 8'hFF, '1);          // slot 0, all-ones record
        send_command(CMD_ALLOC, 8'h00, '0);          // slot 1, all-zero record
        send_command(CMD_READ,  8'h00, '0);
        send_command(CMD_READ,  8'h01, '1);
        send_command(CMD_WRITE, 8'h00, record_t'(40'hA5_5A3C_C3_96));
        send_command(CMD_READ,  8'h00, '0);
        send_command(CMD_FREE,  8'h01, '0);
        send_command(CMD_FREE,  8'h01, '0);          // already free: ok, no change
        send_command(CMD_READ,  8'h01, '0);          // free slot reads back empty
        send_command(CMD_WRITE, 8'h01, '1);          // write to a free slot is refused
        send_command(CMD_READ,  8'h02, '0);          // just past the used end
        send_command(CMD_FREE,  8'hC8, '0);
        send_command(CMD_ALLOC, 8'h00, record_t'(40'h01_2345_6789)); // reuses slot 1
        send_command(CMD_FREE,  8'h00, '0);
        send_command(CMD_FREE,  8'h01, '0);
        send_command(CMD_ALLOC, 8'h00, random_record());  // list order: 1 then 0
        send_command(CMD_ALLOC, 8'h00, random_record());
        send_command(CMD_ALLOC, 8'h00, random_record());  // list empty, grows to 2
        send_command(CMD_READ,  8'h02, '0);
    endtask

    // receiver stops for a long stretch while commands keep coming back to back
    task automatic test_result_backpressure();
        int   i;
        cmd_t cmd;
        wait_for_replies();
        src_idle     = 1'b0;
        hold_request = 1'b1;
        for (i = 0; i < 30; i++) begin
            cmd = pick_command(25, 25, 25);
            send_command(cmd, pick_slot(cmd), random_record());
        end
        wait_for_replies();
    endtask

    task automatic run_random(input int count, input int w_alloc, input int w_free,
                              input int w_read);
        int   i;
        cmd_t cmd;
        for (i = 0; i < count; i++) begin
            // new idling mix every so often, with idle-free stretches in between
            if (i % 50 == 0) begin
                src_idle  = $urandom_range(0, 3) != 0;
                sink_idle = $urandom_range(0, 3) != 0;
            end
            cmd = pick_command(w_alloc, w_free, w_read);
            send_command(cmd, pick_slot(cmd), random_record());
        end
    endtask

    // grow to capacity, hit full, and work the last slot
    task automatic test_fill_table();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        while (list_head < SLOT_COUNT || table_end < SLOT_COUNT)
            send_command(CMD_ALLOC, SLOT_FIELD_W'($urandom), random_record());
        repeat (3) send_command(CMD_ALLOC, SLOT_FIELD_W'($urandom), random_record());
        send_command(CMD_READ,  8'hFF, '0);
        send_command(CMD_WRITE, 8'hFF, '1);
        send_command(CMD_READ,  8'hFF, '0);
        send_command(CMD_FREE,  8'hFF, '0);
        send_command(CMD_ALLOC, 8'h00, random_record());  // slot 255 again
        send_command(CMD_ALLOC, 8'h00, random_record());  // full
        wait_for_replies();
    endtask

    // result sink: per-beat ready gaps, the long hold on request, and the check
    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            gap = sink_idle ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_reply();
        end
    end

    // no beat on either side for too long means the block is hung
    initial begin : stall_watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_command      <= CMD_READ;
        s_slot         <= '0;
        s_mailbox      <= '0;
        s_message_code <= '0;
        s_wait_state   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        test_empty_table();
        test_basic_ops();
        wait_for_replies();
        test_result_backpressure();
        // small table: growth, churn and plenty of beyond-end slots
        run_random(600, 30, 25, 25);
        wait_for_replies();
        test_fill_table();
        // table at capacity: free list churn with full hits in between
        run_random(740, 30, 30, 25);

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

endmodule
